// ===== hw/rtl/lru_pkg.sv =====
// ============================================================================
// LRU page replacement package
// Fixed field widths, configuration reset value and the control bundle that
// the sequencer hands to the frame search unit.
// ============================================================================
package lru_pkg;

  // Width of the frame count register and of its write data.
  localparam int unsigned CFG_W = 5;
  // Reset value of the frame count register.
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;
  // Fixed widths of the result fields.
  localparam int unsigned FRAME_OUT_W = 4;
  localparam int unsigned EVICT_W = 16;
  localparam int unsigned COUNT_W = 32;

  // Control from the sequencer to the search unit.
  typedef struct packed {
    logic clear;   // a new reference has been taken: forget the previous search
    logic sample;  // frame data read from the memories is valid this cycle
  } scan_ctl_t;

endpackage

// ===== hw/rtl/lru_page_replacement_unit.sv =====
// ============================================================================
// LRU page replacement unit
// Keeps a configurable set of page frames and replaces the least recently
// used one on a page fault; one result per page reference.
// ============================================================================
//
// Usage.
// A reference is taken at a rising edge where start is high and busy is low;
// page is sampled at that edge. Exactly one result follows: done is high for
// a single cycle, and hit, frame_index, evicted_valid, evicted_page,
// fault_count and hit_count are valid in that cycle. The receiver cannot
// stall the unit, so each result must be taken when done is shown.
// The frame count register is written through its own channel (cfg_valid,
// cfg_ready, cfg_data); the user must write it only while the unit is idle,
// which the unit itself does not enforce. cfg_ready is always high.
//
// Timing. Frame pages and recency ranks live in two synchronous RAMs. Each
// reference makes a search pass over the L = min(frames in use, filled
// frames) searchable frames, one frame per cycle, followed by a rank update
// pass over all U filled frames, again one frame per cycle as a
// read-modify-write. done rises in the same cycle that busy falls, so a new
// reference can be taken while done is high.
//
// Reset. A synchronous reset empties all frames, clears both counters and
// sets the frame count to 16. No RAM clearing pass is needed: only filled
// frames are ever read, and frames fill in order from frame 0.
// ============================================================================
module lru_page_replacement_unit #(
  parameter int unsigned MAX_FRAMES = 16,
  parameter int unsigned PAGE_BITS  = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [PAGE_BITS-1:0]           page,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lru_pkg::CFG_W-1:0]      cfg_data,
  output logic                           done,
  output logic                           hit,
  output logic [lru_pkg::FRAME_OUT_W-1:0] frame_index,
  output logic                           evicted_valid,
  output logic [lru_pkg::EVICT_W-1:0]    evicted_page,
  output logic [lru_pkg::COUNT_W-1:0]    fault_count,
  output logic [lru_pkg::COUNT_W-1:0]    hit_count
);
  import lru_pkg::*;

  // Frame addresses and ranks share a width; ranks never reach MAX_FRAMES.
  localparam int unsigned FRAME_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int unsigned RANK_W  = FRAME_W;
  // Frame counts run from zero up to MAX_FRAMES inclusive.
  localparam int unsigned CNT_W   = $clog2(MAX_FRAMES + 1);
  localparam int unsigned NW      = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int unsigned FIW     = (FRAME_W > FRAME_OUT_W) ? FRAME_W : FRAME_OUT_W;
  localparam int unsigned EPW     = (PAGE_BITS > EVICT_W) ? PAGE_BITS : EVICT_W;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DECIDE = 4'b0100,
    ST_UPDATE = 4'b1000
  } state_t;

  state_t               state;
  logic [CFG_W-1:0]     frames_in_use;
  logic [CNT_W-1:0]     filled_frames;
  logic [CNT_W-1:0]     scan_len;
  logic [CNT_W-1:0]     upd_len;
  logic [CNT_W-1:0]     idx;
  logic [CNT_W-1:0]     n_eff;
  logic [CNT_W-1:0]     limit;
  logic [NW-1:0]        cfg_ext;
  logic [PAGE_BITS-1:0] page_q;
  logic [PAGE_BITS-1:0] ev_page;
  logic [FRAME_W-1:0]   frame_q;
  logic [RANK_W-1:0]    old_rank;
  logic                 age_all;
  logic                 rd_vld;
  logic [FRAME_W-1:0]   rd_idx;
  logic                 issue;
  logic                 accept;
  logic                 fill;
  logic [FIW-1:0]       frame_ext;
  logic [EPW-1:0]       ev_ext;

  // Memory ports.
  logic                 pg_we;
  logic [FRAME_W-1:0]   pg_waddr;
  logic                 pg_re;
  logic [PAGE_BITS-1:0] pg_rdata;
  logic                 rk_we;
  logic [FRAME_W-1:0]   rk_waddr;
  logic [RANK_W-1:0]    rk_wdata;
  logic                 rk_re;
  logic [RANK_W-1:0]    rk_rdata;

  // Search results.
  scan_ctl_t            scan_ctl;
  logic                 s_hit;
  logic [FRAME_W-1:0]   s_hit_frame;
  logic [RANK_W-1:0]    s_hit_rank;
  logic [FRAME_W-1:0]   s_best_frame;
  logic [RANK_W-1:0]    s_best_rank;
  logic [PAGE_BITS-1:0] s_best_page;

  assign cfg_ready = 1'b1;
  assign busy      = (state != ST_IDLE);
  assign accept    = (state == ST_IDLE) && start;

  // A frame count of zero acts as one, and counts above the built size are
  // clipped to it.
  assign cfg_ext = NW'(frames_in_use);
  always_comb begin
    if (cfg_ext == '0) begin
      n_eff = CNT_W'(1);
    end else if (cfg_ext > NW'(MAX_FRAMES)) begin
      n_eff = CNT_W'(MAX_FRAMES);
    end else begin
      n_eff = CNT_W'(cfg_ext);
    end
  end

  // One frame is read per cycle in both passes; the index runs up to the
  // length of the current pass.
  assign limit = (state == ST_SCAN) ? scan_len : upd_len;
  assign issue = ((state == ST_SCAN) || (state == ST_UPDATE)) && (idx < limit);

  // On a fault with free frames left, the next empty frame is filled.
  assign fill = !s_hit && (filled_frames < n_eff);

  assign pg_re    = issue && (state == ST_SCAN);
  assign rk_re    = issue;
  assign pg_we    = (state == ST_DECIDE) && !s_hit;
  assign pg_waddr = fill ? filled_frames[FRAME_W-1:0] : s_best_frame;

  // Rank update: the touched frame becomes the youngest, and every frame
  // younger than its old rank ages by one. A filled frame ages everything.
  assign rk_we    = (state == ST_UPDATE) && rd_vld &&
                    ((rd_idx == frame_q) || age_all || (rk_rdata < old_rank));
  assign rk_waddr = rd_idx;
  assign rk_wdata = (rd_idx == frame_q) ? '0 : RANK_W'(rk_rdata + 1'b1);

  assign scan_ctl.clear  = accept;
  assign scan_ctl.sample = (state == ST_SCAN) && rd_vld;

  assign frame_ext    = FIW'(frame_q);
  assign frame_index  = frame_ext[FRAME_OUT_W-1:0];
  assign ev_ext       = EPW'(ev_page);
  assign evicted_page = ev_ext[EVICT_W-1:0];

  lru_ram #(
    .WIDTH (PAGE_BITS),
    .DEPTH (MAX_FRAMES)
  ) u_page_ram (
    .clk   (clk),
    .we    (pg_we),
    .waddr (pg_waddr),
    .wdata (page_q),
    .re    (pg_re),
    .raddr (idx[FRAME_W-1:0]),
    .rdata (pg_rdata)
  );

  lru_ram #(
    .WIDTH (RANK_W),
    .DEPTH (MAX_FRAMES)
  ) u_rank_ram (
    .clk   (clk),
    .we    (rk_we),
    .waddr (rk_waddr),
    .wdata (rk_wdata),
    .re    (rk_re),
    .raddr (idx[FRAME_W-1:0]),
    .rdata (rk_rdata)
  );

  lru_search #(
    .FRAME_W   (FRAME_W),
    .RANK_W    (RANK_W),
    .PAGE_BITS (PAGE_BITS)
  ) u_search (
    .clk        (clk),
    .rst        (rst),
    .ctl        (scan_ctl),
    .frame      (rd_idx),
    .page       (page_q),
    .page_rdata (pg_rdata),
    .rank_rdata (rk_rdata),
    .hit        (s_hit),
    .hit_frame  (s_hit_frame),
    .hit_rank   (s_hit_rank),
    .best_frame (s_best_frame),
    .best_rank  (s_best_rank),
    .best_page  (s_best_page)
  );

  // Sequencer and control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      frames_in_use <= CFG_RESET;
      filled_frames <= '0;
      fault_count   <= '0;
      hit_count     <= '0;
      done          <= 1'b0;
      rd_vld        <= 1'b0;
    end else begin
      done   <= 1'b0;
      rd_vld <= issue;
      if (cfg_valid && cfg_ready) begin
        frames_in_use <= cfg_data;
      end
      case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // The last frame's data is taken by the search unit in this cycle.
          if (!issue) begin
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          state <= ST_UPDATE;
          if (s_hit) begin
            if (hit_count != '1) begin
              hit_count <= hit_count + 1'b1;
            end
          end else begin
            if (fault_count != '1) begin
              fault_count <= fault_count + 1'b1;
            end
            if (fill) begin
              filled_frames <= filled_frames + 1'b1;
            end
          end
        end
        ST_UPDATE: begin
          if (!issue) begin
            state <= ST_IDLE;
            done  <= 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Index, captured reference and result fields.
  always_ff @(posedge clk) begin
    rd_idx <= idx[FRAME_W-1:0];
    if (issue) begin
      idx <= idx + 1'b1;
    end
    if (accept) begin
      page_q   <= page;
      idx      <= '0;
      scan_len <= (n_eff < filled_frames) ? n_eff : filled_frames;
    end
    if (state == ST_DECIDE) begin
      idx <= '0;
      hit <= s_hit;
      if (s_hit) begin
        frame_q       <= s_hit_frame;
        old_rank      <= s_hit_rank;
        age_all       <= 1'b0;
        evicted_valid <= 1'b0;
        ev_page       <= '0;
        upd_len       <= filled_frames;
      end else if (fill) begin
        frame_q       <= filled_frames[FRAME_W-1:0];
        old_rank      <= '0;
        age_all       <= 1'b1;
        evicted_valid <= 1'b0;
        ev_page       <= '0;
        upd_len       <= filled_frames + 1'b1;
      end else begin
        frame_q       <= s_best_frame;
        old_rank      <= s_best_rank;
        age_all       <= 1'b0;
        evicted_valid <= 1'b1;
        ev_page       <= s_best_page;
        upd_len       <= filled_frames;
      end
    end
  end

  // The update pass writes the frame read in the cycle before while reading
  // the next, so the rank RAM never sees both ports on one entry.
  a_rank_no_clash: assert property (@(posedge clk) disable iff (rst)
    (rk_we && rk_re) |-> (rk_waddr != idx[FRAME_W-1:0]))
    else $error("rank RAM read and write on the same entry");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held for more than one cycle");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while a transaction is still in progress");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    done |-> !(hit && evicted_valid))
    else $error("a hit reported an eviction");

  a_filled_bound: assert property (@(posedge clk) disable iff (rst)
    filled_frames <= CNT_W'(MAX_FRAMES))
    else $error("more frames filled than built");

endmodule

// ===== hw/rtl/lru_ram.sv =====
// ============================================================================
// LRU generic RAM
// Single write port, single read port, read data registered.
// ============================================================================
module lru_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/lru_search.sv =====
// ============================================================================
// LRU frame search unit
// Watches the frames as they stream out of the memories and keeps the first
// frame holding the requested page and the oldest frame seen so far.
// ============================================================================
module lru_search #(
  parameter int unsigned FRAME_W   = 4,
  parameter int unsigned RANK_W    = 4,
  parameter int unsigned PAGE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  lru_pkg::scan_ctl_t    ctl,
  input  logic [FRAME_W-1:0]    frame,
  input  logic [PAGE_BITS-1:0]  page,
  input  logic [PAGE_BITS-1:0]  page_rdata,
  input  logic [RANK_W-1:0]     rank_rdata,
  output logic                  hit,
  output logic [FRAME_W-1:0]    hit_frame,
  output logic [RANK_W-1:0]     hit_rank,
  output logic [FRAME_W-1:0]    best_frame,
  output logic [RANK_W-1:0]     best_rank,
  output logic [PAGE_BITS-1:0]  best_page
);
  import lru_pkg::*;

  logic match;

  assign match = ctl.sample && !hit && (page_rdata == page);

  // Only the first match counts, as a page may sit in two frames.
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      hit <= 1'b0;
    end else if (match) begin
      hit <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (match) begin
      hit_frame <= frame;
      hit_rank  <= rank_rdata;
    end
    // Ranks of valid frames are distinct, so the strictly larger test is exact.
    if (ctl.sample && ((frame == '0) || (rank_rdata > best_rank))) begin
      best_frame <= frame;
      best_rank  <= rank_rdata;
      best_page  <= page_rdata;
    end
  end

endmodule

// ===== test/lru_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU page replacement result checker
// Watches the reference, result and frame count channels, predicts every
// result from its own model of the frames and compares it field by field.
// ----------------------------------------------------------------------------
module lru_result_checker #(
  parameter int unsigned MAX_FRAMES = 16,
  parameter int unsigned PAGE_BITS  = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic                             busy,
  input  logic [PAGE_BITS-1:0]             page,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [lru_pkg::CFG_W-1:0]        cfg_data,
  input  logic                             done,
  input  logic                             hit,
  input  logic [lru_pkg::FRAME_OUT_W-1:0]  frame_index,
  input  logic                             evicted_valid,
  input  logic [lru_pkg::EVICT_W-1:0]      evicted_page,
  input  logic [lru_pkg::COUNT_W-1:0]      fault_count,
  input  logic [lru_pkg::COUNT_W-1:0]      hit_count,
  output int unsigned                      mismatches,
  output int unsigned                      pending
);

  localparam int unsigned FI_W = lru_pkg::FRAME_OUT_W;
  localparam int unsigned EV_W = lru_pkg::EVICT_W;
  localparam int unsigned CN_W = lru_pkg::COUNT_W;
  localparam logic [CN_W-1:0] COUNT_TOP = '1;

  typedef struct packed {
    logic            hit;
    logic [FI_W-1:0] frame_index;
    logic            evicted_valid;
    logic [EV_W-1:0] evicted_page;
    logic [CN_W-1:0] fault_count;
    logic [CN_W-1:0] hit_count;
  } lru_result_t;

  // Shadow copy of the unit's frames, ages and counters.
  logic [PAGE_BITS-1:0]    held_page [MAX_FRAMES];
  bit                      held      [MAX_FRAMES];
  int unsigned             age       [MAX_FRAMES];
  int unsigned             filled;
  logic [CN_W-1:0]         faults;
  logic [CN_W-1:0]         hits;
  logic [lru_pkg::CFG_W-1:0] frame_limit;

  lru_result_t expected_results[$];
  lru_result_t want;

  // Frame f becomes the youngest; valid frames younger than its old age step back.
  function automatic void make_youngest(int unsigned f, int unsigned old_age);
    for (int unsigned j = 0; j < MAX_FRAMES; j++) begin
      if (held[j] && j != f && age[j] < old_age) age[j]++;
    end
    age[f] = 0;
  endfunction

  function automatic lru_result_t lru_lookup(logic [PAGE_BITS-1:0] p);
    lru_result_t r;
    int unsigned n;
    int unsigned f;
    int unsigned oldest;
    int unsigned oldest_age;
    bit found;
    r = '0;
    found = 0;
    f = 0;
    // A count of zero behaves as one, anything above the built size as the maximum.
    n = (frame_limit == 0) ? 1 :
        ((frame_limit > MAX_FRAMES) ? MAX_FRAMES : 32'(frame_limit));
    for (int unsigned k = 0; k < n; k++) begin
      if (!found && held[k] && held_page[k] == p) begin
        found = 1;
        f = k;
      end
    end
    if (found) begin
      make_youngest(f, age[f]);
      if (hits != COUNT_TOP) hits++;
    end else begin
      if (filled < n) begin
        f = filled;
        held[f] = 1;
        held_page[f] = p;
        make_youngest(f, MAX_FRAMES + 1);
        filled++;
      end else begin
        // The first frame with the greatest age is the victim.
        oldest = 0;
        oldest_age = 0;
        for (int unsigned k = 0; k < n; k++) begin
          if (held[k] && (k == 0 || age[k] > oldest_age)) begin
            oldest = k;
            oldest_age = age[k];
          end
        end
        f = oldest;
        r.evicted_valid = 1'b1;
        r.evicted_page = EV_W'(held_page[f]);
        held_page[f] = p;
        make_youngest(f, oldest_age);
      end
      if (faults != COUNT_TOP) faults++;
    end
    r.hit = found;
    r.frame_index = FI_W'(f);
    r.fault_count = faults;
    r.hit_count = hits;
    return r;
  endfunction

  task automatic report(string field, logic [CN_W-1:0] exp_v, logic [CN_W-1:0] act_v);
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_v, act_v);
    mismatches++;
  endtask

  initial begin
    mismatches = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      for (int unsigned k = 0; k < MAX_FRAMES; k++) begin
        held[k] = 0;
        age[k] = 0;
        held_page[k] = '0;
      end
      filled = 0;
      faults = '0;
      hits = '0;
      frame_limit = lru_pkg::CFG_RESET;
      expected_results.delete();
    end else begin
      if (done) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with nothing expected, actual frame %0d page %0h",
                   $time, frame_index, evicted_page);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (hit !== want.hit) report("hit", CN_W'(want.hit), CN_W'(hit));
          if (frame_index !== want.frame_index)
            report("frame_index", CN_W'(want.frame_index), CN_W'(frame_index));
          if (evicted_valid !== want.evicted_valid)
            report("evicted_valid", CN_W'(want.evicted_valid), CN_W'(evicted_valid));
          if (evicted_page !== want.evicted_page)
            report("evicted_page", CN_W'(want.evicted_page), CN_W'(evicted_page));
          if (fault_count !== want.fault_count)
            report("fault_count", want.fault_count, fault_count);
          if (hit_count !== want.hit_count) report("hit_count", want.hit_count, hit_count);
        end
      end
      if (cfg_valid && cfg_ready) frame_limit = cfg_data;
      if (start && !busy) expected_results.push_back(lru_lookup(page));
    end
    pending = expected_results.size();
  end

endmodule

// ===== test/lru_page_replacement_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU page replacement unit testbench
// Drives page references and frame count writes into the unit, leaves the
// prediction and comparison to the result checker and gives the verdict.
// ----------------------------------------------------------------------------
module lru_page_replacement_unit_tb;

  localparam int unsigned MAX_FRAMES = 16;
  localparam int unsigned PAGE_BITS  = 16;
  // The settle time after draining is comfortably longer than the slowest
  // transaction.
  localparam int unsigned SETTLE = 40;
  // Roughly 720 references, even with the slowest transaction and longest gap
  // for each, come to far less than the limit, which leaves ample headroom.
  localparam int unsigned CYCLE_LIMIT = 500000;

  logic                               clk;
  logic                               rst;
  logic                               start;
  logic                               busy;
  logic [PAGE_BITS-1:0]               page;
  logic                               cfg_valid;
  logic                               cfg_ready;
  logic [lru_pkg::CFG_W-1:0]          cfg_data;
  logic                               done;
  logic                               hit;
  logic [lru_pkg::FRAME_OUT_W-1:0]    frame_index;
  logic                               evicted_valid;
  logic [lru_pkg::EVICT_W-1:0]        evicted_page;
  logic [lru_pkg::COUNT_W-1:0]        fault_count;
  logic [lru_pkg::COUNT_W-1:0]        hit_count;
  int unsigned                        mismatches;
  int unsigned                        pending;
  int unsigned                        cycles;

  lru_page_replacement_unit #(
    .MAX_FRAMES(MAX_FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .page         (page),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .done         (done),
    .hit          (hit),
    .frame_index  (frame_index),
    .evicted_valid(evicted_valid),
    .evicted_page (evicted_page),
    .fault_count  (fault_count),
    .hit_count    (hit_count)
  );

  // The checker sits beside the unit and sees exactly what the unit sees.
  lru_result_checker #(
    .MAX_FRAMES(MAX_FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) checker_i (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .page         (page),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .done         (done),
    .hit          (hit),
    .frame_index  (frame_index),
    .evicted_valid(evicted_valid),
    .evicted_page (evicted_page),
    .fault_count  (fault_count),
    .hit_count    (hit_count),
    .mismatches   (mismatches),
    .pending      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run here rather than running forever.
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Offers one reference and holds it until the unit takes it. With the given
  // percentage chance an idle gap of random length comes first, long enough to
  // land anywhere within the unit's search and rank update passes.
  task automatic send_page(logic [PAGE_BITS-1:0] p, int unsigned idle_pct);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
    start <= 1'b1;
    page  <= p;
    do @(posedge clk); while (busy);
  endtask

  // Stops sending, waits for every outstanding result and lets the unit settle.
  // The pending count is read at the falling edge so that it is stable.
  task automatic wait_drained();
    start <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // One transaction on the frame count channel; only called when idle.
  task automatic write_frames(logic [lru_pkg::CFG_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [PAGE_BITS-1:0] pool [20];
    int unsigned frame_plan [10];
    int unsigned idle_plan [3];
    int unsigned active;
    int unsigned span;
    int unsigned idle_pct;

    frame_plan = '{16, 1, 0, 31, 4, 17, 8, 2, 0, 16};
    idle_plan  = '{0, 68, 21};
    frame_plan[8] = $urandom_range(0, 31);

    rst       <= 1'b1;
    start     <= 1'b0;
    page      <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. The unit starts with all 16 frames in use: fill a few,
    // including the all-zero and all-ones pages, and hit one of them.
    send_page(16'h0000, 0);
    send_page(16'hFFFF, 0);
    send_page(16'h0000, 0);
    send_page(16'hA5A5, 0);
    send_page(16'h5A5A, 0);

    // Shrink to two frames: pages held above frame 1 are no longer matched,
    // so a reference to one of them faults and evicts from the lower frames.
    wait_drained();
    write_frames(5'd2);
    send_page(16'hA5A5, 0);
    send_page(16'hFFFF, 0);
    send_page(16'h1234, 0);
    send_page(16'h1234, 0);

    // A frame count of zero behaves as a single frame.
    wait_drained();
    write_frames(5'd0);
    send_page(16'h0001, 0);
    send_page(16'h0001, 0);
    send_page(16'h8000, 0);

    // Too large a count behaves as the full 16; the frames left empty fill
    // in order before anything is replaced, and the higher frames match again.
    wait_drained();
    write_frames(5'd31);
    send_page(16'h5A5A, 0);
    send_page(16'h1111, 0);
    send_page(16'h2222, 0);

    wait_drained();
    write_frames(5'd17);
    send_page(16'h0F0F, 0);
    send_page(16'hF0F0, 0);

    // Random part: ten phases, each with its own frame count and one of three
    // sender behaviours. Most references come from a small working set sized
    // to the frame count so that hits and evictions of the oldest frame both
    // occur; the rest are arbitrary pages.
    for (int ph = 0; ph < 10; ph++) begin
      wait_drained();
      write_frames(frame_plan[ph][lru_pkg::CFG_W-1:0]);
      active = (frame_plan[ph] == 0) ? 1 :
               ((frame_plan[ph] > MAX_FRAMES) ? MAX_FRAMES : frame_plan[ph]);
      span = (active + 2 > 19) ? 19 : active + 2;
      idle_pct = idle_plan[ph % 3];
      for (int k = 0; k < 20; k++) pool[k] = PAGE_BITS'($urandom);
      for (int i = 0; i < 70; i++) begin
        // Once, part way through a phase, let the unit run completely dry.
        if (ph == 4 && i == 35) wait_drained();
        if ($urandom_range(0, 99) < 80)
          send_page(pool[$urandom_range(0, span)], idle_pct);
        else
          send_page(PAGE_BITS'($urandom), idle_pct);
      end
    end

    wait_drained();
    if (mismatches == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/lru_pkg.sv
hw/rtl/lru_ram.sv
hw/rtl/lru_search.sv
hw/rtl/lru_page_replacement_unit.sv
test/lru_result_checker.sv
test/lru_page_replacement_unit_tb.sv
